// ----- hdl/worker_pool_call_dispatcher_defines.svh -----
// Assertion macros for the worker pool call dispatcher.
// No dependencies; included by the top level.
`ifndef WORKER_POOL_CALL_DISPATCHER_DEFINES_SVH
`define WORKER_POOL_CALL_DISPATCHER_DEFINES_SVH
`ifndef SYNTH
`define WPCD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("wpcd assertion failed");
`define WPCD_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("wpcd assertion failed");
`else
`define WPCD_ASSERT(lbl, prop)
`define WPCD_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- hdl/wpcd_pkg.sv -----
// Types and codes shared by the worker pool call dispatcher modules.
// No dependencies.
package wpcd_pkg;
	localparam int WID_IN_W = 6;
	localparam int CALL_W = 32;
	localparam int TAG_W = 16;
	localparam int CNT_OUT_W = 7;
	localparam logic [CNT_OUT_W-1:0] CNT_SAT = 7'd127;

	typedef enum logic [2:0] {
		CMD_CONNECT = 3'd0,
		CMD_DISCONNECT = 3'd1,
		CMD_NEW_CALL = 3'd2,
		CMD_COMPLETED = 3'd3,
		CMD_FAILED = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE = 3'd0,
		ST_QUEUED = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_FULL = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		K_CONNECT,
		K_DISCONNECT,
		K_NEW,
		K_FINISH,
		K_BAD
	} kind_t;

	// one classified word between front and back
	typedef struct packed {
		kind_t kind;
		logic wid_ok;
		logic [WID_IN_W-1:0] wid;
		logic [CALL_W-1:0] call;
		logic [TAG_W-1:0] tag;
	} item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_FREE,
		S_FREE_RD,
		S_POP,
		S_POP_RD,
		S_SCAN,
		S_SCAN_CMP,
		S_REPLY
	} state_t;
endpackage

// ----- hdl/wpcd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/wpcd_front.sv -----
// Front end: accepts command words, classifies them, and holds them in a
// two-entry queue for the back end. Depends on wpcd_pkg.
module wpcd_front import wpcd_pkg::*; #(
	parameter int WORKER_SLOTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          command,
	input  logic [WID_IN_W-1:0] worker_id,
	input  logic [CALL_W-1:0]   call_id,
	input  logic [TAG_W-1:0]    payload_tag,
	output item_t               item,
	output logic                item_valid,
	input  logic                item_pop
);
	item_t       slot_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       cls;

	// classify the incoming word
	always_comb begin
		cls.wid = worker_id;
		cls.call = call_id;
		cls.tag = payload_tag;
		cls.wid_ok = 32'(worker_id) < WORKER_SLOTS;
		unique case (command)
			CMD_CONNECT:    cls.kind = K_CONNECT;
			CMD_DISCONNECT: cls.kind = K_DISCONNECT;
			CMD_NEW_CALL:   cls.kind = K_NEW;
			CMD_COMPLETED,
			CMD_FAILED:     cls.kind = K_FINISH;
			default:        cls.kind = K_BAD;
		endcase
	end

	assign busy = count_q == 2'd2;
	assign push = start && !busy;
	assign item_valid = count_q != 2'd0;
	assign item = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (item_pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(item_pop);
		end
	end
endmodule

// ----- hdl/wpcd_back.sv -----
// Back end: sequencer that runs one command word at a time against the
// worker flags, idle stack, pending queue and running-call table.
// Depends on wpcd_pkg and wpcd_ram.
module wpcd_back import wpcd_pkg::*; #(
	parameter int WORKER_SLOTS = 64,
	parameter int PENDING_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  item_t                item,
	input  logic                 item_valid,
	output logic                 item_pop,
	output logic                 result_valid,
	output logic                 dispatched,
	output logic [WID_IN_W-1:0]  dispatch_worker,
	output logic [CALL_W-1:0]    dispatch_call_id,
	output logic [TAG_W-1:0]     dispatch_tag,
	output logic [2:0]           status,
	output logic [CNT_OUT_W-1:0] idle_count,
	output logic [CNT_OUT_W-1:0] running_count
);
	localparam int WID_W = $clog2(WORKER_SLOTS);
	localparam int TOP_W = $clog2(WORKER_SLOTS + 1);
	localparam int PD_W = $clog2(PENDING_DEPTH);
	localparam int PC_W = $clog2(PENDING_DEPTH + 1);
	localparam int PEND_W = CALL_W + TAG_W;

	state_t                  state_q, state_d;
	item_t                   cur_q, cur_d;
	logic [WID_W-1:0]        wsel_q, wsel_d, scan_q, scan_d;
	logic [WORKER_SLOTS-1:0] conn_q, conn_d, run_q, run_d;
	logic [TOP_W-1:0]        top_q, top_d, idle_cnt_q, idle_cnt_d, run_cnt_q, run_cnt_d;
	logic [PD_W-1:0]         head_q, head_d, tail_q, tail_d;
	logic [PC_W-1:0]         cnt_q, cnt_d;
	status_t                 res_status_q, res_status_d;
	logic                    res_disp_q, res_disp_d;
	logic [WID_IN_W-1:0]     res_w_q, res_w_d;
	logic [CALL_W-1:0]       res_call_q, res_call_d;
	logic [TAG_W-1:0]        res_tag_q, res_tag_d;

	logic                    rc_we, stk_we, pd_we;
	logic [WID_W-1:0]        rc_waddr, rc_raddr, stk_waddr, stk_raddr, stk_wdata, stk_rdata;
	logic [CALL_W-1:0]       rc_wdata, rc_rdata;
	logic [PD_W-1:0]         pd_raddr;
	logic [PEND_W-1:0]       pd_wdata, pd_rdata;
	logic [WID_W-1:0]        idx, pw;
	logic [TOP_W-1:0]        top_dec;

	// running call per worker
	wpcd_ram #(.WIDTH(CALL_W), .DEPTH(WORKER_SLOTS)) u_run_call (
		.clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
		.raddr(rc_raddr), .rdata(rc_rdata)
	);

	// LIFO of idle workers
	wpcd_ram #(.WIDTH(WID_W), .DEPTH(WORKER_SLOTS)) u_idle_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// FIFO of pending calls, call id over tag
	wpcd_ram #(.WIDTH(PEND_W), .DEPTH(PENDING_DEPTH)) u_pending (
		.clk(clk), .we(pd_we), .waddr(tail_q), .wdata(pd_wdata),
		.raddr(pd_raddr), .rdata(pd_rdata)
	);

	assign idx = WID_W'(cur_q.wid);
	assign pw = stk_rdata;
	assign top_dec = top_q - 1'b1;

	// next state and datapath
	always_comb begin
		state_d = state_q;
		cur_d = cur_q;
		wsel_d = wsel_q;
		scan_d = scan_q;
		conn_d = conn_q;
		run_d = run_q;
		top_d = top_q;
		idle_cnt_d = idle_cnt_q;
		run_cnt_d = run_cnt_q;
		head_d = head_q;
		tail_d = tail_q;
		cnt_d = cnt_q;
		res_status_d = res_status_q;
		res_disp_d = res_disp_q;
		res_w_d = res_w_q;
		res_call_d = res_call_q;
		res_tag_d = res_tag_q;
		item_pop = 1'b0;
		rc_we = 1'b0;
		rc_waddr = wsel_q;
		rc_wdata = cur_q.call;
		rc_raddr = scan_q;
		stk_we = 1'b0;
		stk_waddr = top_q[WID_W-1:0];
		stk_wdata = wsel_q;
		stk_raddr = top_dec[WID_W-1:0];
		pd_we = 1'b0;
		pd_wdata = {cur_q.call, cur_q.tag};
		pd_raddr = head_q;

		unique case (state_q)
			S_IDLE: begin
				res_disp_d = 1'b0;
				res_w_d = '0;
				res_call_d = '0;
				res_tag_d = '0;
				if (item_valid) begin
					item_pop = 1'b1;
					cur_d = item;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_REPLY;
				res_status_d = ST_IGNORED;
				unique case (cur_q.kind)
					K_CONNECT: begin
						if (cur_q.wid_ok && !conn_q[idx]) begin
							conn_d[idx] = 1'b1;
							res_status_d = ST_DONE;
							if (!run_q[idx]) begin
								idle_cnt_d = idle_cnt_q + 1'b1;
								wsel_d = idx;
								state_d = S_FREE;
							end
						end
					end
					K_DISCONNECT: begin
						if (cur_q.wid_ok && conn_q[idx]) begin
							conn_d[idx] = 1'b0;
							res_status_d = ST_DONE;
							if (!run_q[idx])
								idle_cnt_d = idle_cnt_q - 1'b1;
						end
					end
					K_NEW:
						state_d = S_POP;
					K_FINISH: begin
						scan_d = '0;
						state_d = S_SCAN;
					end
					K_BAD: ;
					default: ;
				endcase
			end
			// freed worker: take oldest pending call, else go on the stack unless it is full
			S_FREE: begin
				state_d = S_REPLY;
				if (cnt_q != '0) begin
					state_d = S_FREE_RD;
				end else if (32'(top_q) == WORKER_SLOTS) begin
					res_status_d = ST_FULL;
				end else begin
					stk_we = 1'b1;
					top_d = top_q + 1'b1;
					res_status_d = ST_DONE;
				end
			end
			S_FREE_RD: begin
				run_d[wsel_q] = 1'b1;
				rc_we = 1'b1;
				rc_wdata = pd_rdata[PEND_W-1:TAG_W];
				idle_cnt_d = idle_cnt_q - 1'b1;
				run_cnt_d = run_cnt_q + 1'b1;
				res_disp_d = 1'b1;
				res_w_d = WID_IN_W'(wsel_q);
				res_call_d = pd_rdata[PEND_W-1:TAG_W];
				res_tag_d = pd_rdata[TAG_W-1:0];
				head_d = (32'(head_q) == PENDING_DEPTH - 1) ? '0 : head_q + 1'b1;
				cnt_d = cnt_q - 1'b1;
				res_status_d = ST_DONE;
				state_d = S_REPLY;
			end
			// new call: pop stack until a live idle worker shows up, else queue the call
			S_POP: begin
				if (top_q != '0) begin
					top_d = top_dec;
					state_d = S_POP_RD;
				end else if (32'(cnt_q) == PENDING_DEPTH) begin
					res_status_d = ST_FULL;
					state_d = S_REPLY;
				end else begin
					pd_we = 1'b1;
					tail_d = (32'(tail_q) == PENDING_DEPTH - 1) ? '0 : tail_q + 1'b1;
					cnt_d = cnt_q + 1'b1;
					res_status_d = ST_QUEUED;
					state_d = S_REPLY;
				end
			end
			S_POP_RD: begin
				if (conn_q[pw] && !run_q[pw]) begin
					run_d[pw] = 1'b1;
					rc_we = 1'b1;
					rc_waddr = pw;
					idle_cnt_d = idle_cnt_q - 1'b1;
					run_cnt_d = run_cnt_q + 1'b1;
					res_disp_d = 1'b1;
					res_w_d = WID_IN_W'(pw);
					res_call_d = cur_q.call;
					res_tag_d = cur_q.tag;
					res_status_d = ST_DONE;
					state_d = S_REPLY;
				end else begin
					state_d = S_POP;
				end
			end
			// completion: walk workers in order looking for the call id
			S_SCAN:
				state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				if (run_q[scan_q] && rc_rdata == cur_q.call) begin
					run_d[scan_q] = 1'b0;
					run_cnt_d = run_cnt_q - 1'b1;
					res_status_d = ST_DONE;
					if (conn_q[scan_q]) begin
						idle_cnt_d = idle_cnt_q + 1'b1;
						wsel_d = scan_q;
						state_d = S_FREE;
					end else begin
						state_d = S_REPLY;
					end
				end else if (32'(scan_q) == WORKER_SLOTS - 1) begin
					res_status_d = ST_UNKNOWN;
					state_d = S_REPLY;
				end else begin
					scan_d = scan_q + 1'b1;
					state_d = S_SCAN;
				end
			end
			S_REPLY:
				state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
	end

	// state register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			conn_q <= '0;
			run_q <= '0;
			top_q <= '0;
			idle_cnt_q <= '0;
			run_cnt_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			conn_q <= conn_d;
			run_q <= run_d;
			top_q <= top_d;
			idle_cnt_q <= idle_cnt_d;
			run_cnt_q <= run_cnt_d;
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q <= cnt_d;
			result_valid <= state_q == S_REPLY;
		end
	end

	// payload registers and result word
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		wsel_q <= wsel_d;
		scan_q <= scan_d;
		res_status_q <= res_status_d;
		res_disp_q <= res_disp_d;
		res_w_q <= res_w_d;
		res_call_q <= res_call_d;
		res_tag_q <= res_tag_d;
		if (state_q == S_REPLY) begin
			dispatched <= res_disp_q;
			dispatch_worker <= res_w_q;
			dispatch_call_id <= res_call_q;
			dispatch_tag <= res_tag_q;
			status <= res_status_q;
			idle_count <= (32'(idle_cnt_q) > 32'(CNT_SAT)) ? CNT_SAT
				: CNT_OUT_W'(idle_cnt_q);
			running_count <= (32'(run_cnt_q) > 32'(CNT_SAT)) ? CNT_SAT
				: CNT_OUT_W'(run_cnt_q);
		end
	end
endmodule

// ----- hdl/worker_pool_call_dispatcher.sv -----
// Worker pool call dispatcher top; uses wpcd_pkg, wpcd_front, wpcd_back, defines header.
// A new call takes longer for each stale idle-stack entry it pops; completion scans
// workers from index 0 until it finds the call id, so its time grows with the index.
// One word in the back end at a time, the next begins in its result cycle; two more queue
// up front. Results cannot be held off. Reset clears flags, pointers and counters at once.
`include "worker_pool_call_dispatcher_defines.svh"
module worker_pool_call_dispatcher import wpcd_pkg::*; #(
	parameter int WORKER_SLOTS = 64,
	parameter int PENDING_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           command,
	input  logic [WID_IN_W-1:0]  worker_id,
	input  logic [CALL_W-1:0]    call_id,
	input  logic [TAG_W-1:0]     payload_tag,
	output logic                 result_valid,
	output logic                 dispatched,
	output logic [WID_IN_W-1:0]  dispatch_worker,
	output logic [CALL_W-1:0]    dispatch_call_id,
	output logic [TAG_W-1:0]     dispatch_tag,
	output logic [2:0]           status,
	output logic [CNT_OUT_W-1:0] idle_count,
	output logic [CNT_OUT_W-1:0] running_count
);
	item_t item;
	logic  item_valid, item_pop;

	wpcd_front #(.WORKER_SLOTS(WORKER_SLOTS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .worker_id(worker_id), .call_id(call_id),
		.payload_tag(payload_tag), .item(item), .item_valid(item_valid),
		.item_pop(item_pop)
	);

	wpcd_back #(.WORKER_SLOTS(WORKER_SLOTS), .PENDING_DEPTH(PENDING_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .item(item), .item_valid(item_valid),
		.item_pop(item_pop), .result_valid(result_valid), .dispatched(dispatched),
		.dispatch_worker(dispatch_worker), .dispatch_call_id(dispatch_call_id),
		.dispatch_tag(dispatch_tag), .status(status), .idle_count(idle_count),
		.running_count(running_count)
	);

	// checks
	`WPCD_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid)
	`WPCD_ASSERT(a_disp_done, !(result_valid && dispatched) || status == ST_DONE)
	`WPCD_ASSERT(a_pop_has_word, !item_pop || item_valid)
endmodule

// ----- sim/worker_pool_call_dispatcher_test.sv -----
// Self-checking bench for worker_pool_call_dispatcher: directed table, bursts, random words.
// Depends on wpcd_pkg and the dispatcher RTL; predicts every result word.
module worker_pool_call_dispatcher_test;
	import wpcd_pkg::*;

	localparam int SLOTS = 64;
	localparam int QDEPTH = 256;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic                 dispatched;
		logic [WID_IN_W-1:0]  worker;
		logic [CALL_W-1:0]    call;
		logic [TAG_W-1:0]     tag;
		status_t              st;
		logic [CNT_OUT_W-1:0] idle;
		logic [CNT_OUT_W-1:0] run;
	} result_word_t;

	typedef struct {
		logic [2:0]          cmd;
		logic [WID_IN_W-1:0] wid;
		logic [CALL_W-1:0]   call;
		logic [TAG_W-1:0]    tag;
		bit                  typed;
		result_word_t        res;
	} cmd_row_t;

	logic clk, arst_n, start, busy;
	logic [2:0] command;
	logic [WID_IN_W-1:0] worker_id;
	logic [CALL_W-1:0] call_id;
	logic [TAG_W-1:0] payload_tag;
	logic result_valid, dispatched;
	logic [WID_IN_W-1:0] dispatch_worker;
	logic [CALL_W-1:0] dispatch_call_id;
	logic [TAG_W-1:0] dispatch_tag;
	logic [2:0] status;
	logic [CNT_OUT_W-1:0] idle_count, running_count;

	// typed expectation travels with the word being offered
	bit cur_typed;
	result_word_t cur_res;

	worker_pool_call_dispatcher uut (.*);

	// pool model
	bit                connected[SLOTS];
	bit                running[SLOTS];
	logic [CALL_W-1:0] run_call[SLOTS];
	int                idle_stack[SLOTS];
	int                stack_top;
	logic [CALL_W-1:0] pend_call[QDEPTH];
	logic [TAG_W-1:0]  pend_tag[QDEPTH];
	int                pend_head, pend_tail, pend_count;

	result_word_t pending_results[$];
	cmd_row_t     table_rows[$];
	logic [CALL_W-1:0] issued_ids[$];
	int errors, words_in, words_out, dispatch_seen, stall_cycles, gap_pct;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report(string field, longint got, longint want);
		errors++;
		$display("[%0t] %s: got %0h, want %0h", $realtime, field, got, want);
	endtask

	function automatic void add_row(cmd_row_t row);
		table_rows.insert(table_rows.size(), row);
	endfunction

	function automatic void note_id(logic [CALL_W-1:0] c);
		issued_ids.insert(issued_ids.size(), c);
	endfunction

	function automatic void launch(int w, logic [CALL_W-1:0] c, logic [TAG_W-1:0] t,
			ref result_word_t r);
		running[w] = 1'b1;
		run_call[w] = c;
		r.dispatched = 1'b1;
		r.worker = w[WID_IN_W-1:0];
		r.call = c;
		r.tag = t;
	endfunction

	// freed worker takes the oldest waiting call, else goes on the stack unless it is full
	function automatic status_t release_worker(int w, ref result_word_t r);
		if (pend_count > 0) begin
			launch(w, pend_call[pend_head], pend_tag[pend_head], r);
			pend_head = (pend_head + 1) % QDEPTH;
			pend_count--;
			return ST_DONE;
		end
		if (stack_top >= SLOTS) return ST_FULL;
		idle_stack[stack_top] = w;
		stack_top++;
		return ST_DONE;
	endfunction

	function automatic result_word_t predict_dispatch(logic [2:0] cmd, logic [WID_IN_W-1:0] wid,
			logic [CALL_W-1:0] c, logic [TAG_W-1:0] t);
		result_word_t r;
		int w, idle, run;
		bit found;
		r = '{1'b0, '0, '0, '0, ST_IGNORED, '0, '0};
		case (cmd)
			CMD_CONNECT: begin
				if (!connected[wid]) begin
					connected[wid] = 1'b1;
					r.st = running[wid] ? ST_DONE : release_worker(wid, r);
				end
			end
			CMD_DISCONNECT: begin
				if (connected[wid]) begin
					connected[wid] = 1'b0;
					r.st = ST_DONE;
				end
			end
			CMD_NEW_CALL: begin
				found = 0;
				// lazy pop: stale entries are dropped
				while (stack_top > 0 && !found) begin
					stack_top--;
					w = idle_stack[stack_top];
					if (connected[w] && !running[w]) begin
						launch(w, c, t, r);
						found = 1;
					end
				end
				if (found) r.st = ST_DONE;
				else if (pend_count >= QDEPTH) r.st = ST_FULL;
				else begin
					pend_call[pend_tail] = c;
					pend_tag[pend_tail] = t;
					pend_tail = (pend_tail + 1) % QDEPTH;
					pend_count++;
					r.st = ST_QUEUED;
				end
			end
			CMD_COMPLETED, CMD_FAILED: begin
				r.st = ST_UNKNOWN;
				found = 0;
				// lowest worker holding the id wins
				for (w = 0; w < SLOTS; w++) begin
					if (!found && running[w] && run_call[w] == c) begin
						found = 1;
						running[w] = 1'b0;
						r.st = connected[w] ? release_worker(w, r) : ST_DONE;
					end
				end
			end
			default: ;
		endcase
		idle = 0;
		run = 0;
		for (w = 0; w < SLOTS; w++) begin
			if (running[w]) run++;
			else if (connected[w]) idle++;
		end
		r.idle = (idle > 127) ? CNT_SAT : CNT_OUT_W'(idle);
		r.run = (run > 127) ? CNT_SAT : CNT_OUT_W'(run);
		return r;
	endfunction

	// scoreboard and watchdog
	always @(posedge clk) begin
		result_word_t want, got_pred;
		if (arst_n) begin
			stall_cycles++;
			if (result_valid) begin
				stall_cycles = 0;
				words_out++;
				if (dispatched) dispatch_seen++;
				if (pending_results.size() == 0) report("unexpected word", status, 0);
				else begin
					want = pending_results.pop_front();
					if (dispatched !== want.dispatched) report("dispatched", dispatched, want.dispatched);
					if (dispatch_worker !== want.worker) report("dispatch_worker", dispatch_worker, want.worker);
					if (dispatch_call_id !== want.call) report("dispatch_call_id", dispatch_call_id, want.call);
					if (dispatch_tag !== want.tag) report("dispatch_tag", dispatch_tag, want.tag);
					if (status !== want.st) report("status", status, want.st);
					if (idle_count !== want.idle) report("idle_count", idle_count, want.idle);
					if (running_count !== want.run) report("running_count", running_count, want.run);
				end
			end
			if (start && !busy) begin
				stall_cycles = 0;
				words_in++;
				got_pred = predict_dispatch(command, worker_id, call_id, payload_tag);
				want = cur_typed ? cur_res : got_pred;
				pending_results.insert(pending_results.size(), want);
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress in %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// offers one word, with an optional random gap before it
	task automatic send(cmd_row_t row);
		int gap;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= row.cmd;
		worker_id <= row.wid;
		call_id <= row.call;
		payload_tag <= row.tag;
		cur_typed <= row.typed;
		cur_res <= row.res;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic cmd_row_t mk(logic [2:0] cmd, int wid, logic [CALL_W-1:0] c,
			logic [TAG_W-1:0] t);
		cmd_row_t row;
		row.cmd = cmd;
		row.wid = WID_IN_W'(wid);
		row.call = c;
		row.tag = t;
		row.typed = 0;
		row.res = '{1'b0, '0, '0, '0, ST_IGNORED, '0, '0};
		return row;
	endfunction

	function automatic cmd_row_t mk_typed(logic [2:0] cmd, int wid, logic [CALL_W-1:0] c,
			logic [TAG_W-1:0] t, result_word_t r);
		cmd_row_t row;
		row = mk(cmd, wid, c, t);
		row.typed = 1;
		row.res = r;
		return row;
	endfunction

	function automatic cmd_row_t random_word();
		int pick;
		logic [CALL_W-1:0] c;
		pick = $urandom_range(99);
		c = ($urandom_range(3) == 0) ? CALL_W'($urandom_range(7)) : $urandom;
		if (pick < 38) begin
			note_id(c);
			return mk(CMD_NEW_CALL, 0, c, TAG_W'($urandom));
		end
		if (pick < 70) begin
			if (issued_ids.size() > 0 && $urandom_range(9) < 8)
				c = issued_ids[$urandom_range(issued_ids.size() - 1)];
			if (issued_ids.size() > 128) void'(issued_ids.pop_front());
			return mk($urandom_range(1) ? CMD_COMPLETED : CMD_FAILED, 0, c, TAG_W'($urandom));
		end
		if (pick < 85)
			return mk(CMD_CONNECT, $urandom_range(SLOTS - 1), $urandom, TAG_W'($urandom));
		if (pick < 96)
			return mk(CMD_DISCONNECT, $urandom_range(SLOTS - 1), $urandom, TAG_W'($urandom));
		return mk(3'($urandom_range(5, 7)), $urandom_range(SLOTS - 1), $urandom,
			TAG_W'($urandom));
	endfunction

	initial begin
		cmd_row_t row;
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		worker_id = '0;
		call_id = '0;
		payload_tag = '0;
		cur_typed = 0;
		cur_res = '{1'b0, '0, '0, '0, ST_IGNORED, '0, '0};
		stack_top = 0;
		pend_head = 0;
		pend_tail = 0;
		pend_count = 0;
		gap_pct = 13;

		// directed table: extremes, every command, the corner cases
		add_row(mk_typed(CMD_NEW_CALL, 0, '1, '1,
			'{1'b0, '0, '0, '0, ST_QUEUED, '0, '0}));
		add_row(mk_typed(CMD_COMPLETED, 0, '1, '0,
			'{1'b0, '0, '0, '0, ST_UNKNOWN, '0, '0}));
		add_row(mk_typed(3'd7, 63, '1, '1,
			'{1'b0, '0, '0, '0, ST_IGNORED, '0, '0}));
		add_row(mk_typed(CMD_CONNECT, 63, '0, '0,
			'{1'b1, 6'd63, '1, '1, ST_DONE, 7'd0, 7'd1}));
		add_row(mk_typed(CMD_CONNECT, 63, '0, '0,
			'{1'b0, '0, '0, '0, ST_IGNORED, 7'd0, 7'd1}));
		add_row(mk_typed(CMD_DISCONNECT, 0, '0, '0,
			'{1'b0, '0, '0, '0, ST_IGNORED, 7'd0, 7'd1}));
		add_row(mk(CMD_CONNECT, 0, '0, '0));
		add_row(mk(CMD_NEW_CALL, 0, '0, '0));
		add_row(mk(CMD_NEW_CALL, 0, 32'd5, 16'd1));
		// disconnect while running, then its failure frees it only
		add_row(mk(CMD_DISCONNECT, 63, '0, '0));
		add_row(mk(CMD_FAILED, 0, '1, '0));
		add_row(mk(CMD_CONNECT, 63, '0, '0));
		add_row(mk(CMD_CONNECT, 1, '0, '0));
		add_row(mk(CMD_CONNECT, 2, '0, '0));
		// two workers share one call id
		add_row(mk(CMD_NEW_CALL, 0, 32'h0000_1234, 16'h8000));
		add_row(mk(CMD_NEW_CALL, 0, 32'h0000_1234, 16'h7fff));
		add_row(mk(CMD_COMPLETED, 0, 32'h0000_1234, '0));
		// reconnect while running
		add_row(mk(CMD_DISCONNECT, 0, '0, '0));
		add_row(mk(CMD_CONNECT, 0, '0, '0));
		add_row(mk(CMD_COMPLETED, 0, '0, '0));
		add_row(mk(3'd5, 0, '0, '0));
		add_row(mk(3'd6, 0, '0, '0));
		add_row(mk(CMD_FAILED, 0, 32'h0000_1234, '1));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[k]) send(table_rows[k]);

		// stack fills with stale entries of one worker toggled on and off
		for (i = 0; i < 70; i++) begin
			send(mk(CMD_CONNECT, 9, $urandom, TAG_W'($urandom)));
			send(mk(CMD_DISCONNECT, 9, $urandom, TAG_W'($urandom)));
		end

		// no connected workers: the pending queue overflows
		gap_pct = 76;
		for (i = 0; i < SLOTS; i++)
			if (connected[i]) send(mk(CMD_DISCONNECT, i, '0, '0));
		for (i = 0; i < QDEPTH + 4; i++) begin
			row = mk(CMD_NEW_CALL, 0, $urandom, TAG_W'($urandom));
			note_id(row.call);
			if (issued_ids.size() > 128) void'(issued_ids.pop_front());
			send(row);
		end
		for (i = 0; i < SLOTS / 2; i++) send(mk(CMD_CONNECT, i, '0, '0));

		// random words in three idling phases
		for (i = 0; i < 144; i++) begin
			gap_pct = (i < 48) ? 13 : (i < 96) ? 76 : 0;
			send(random_word());
		end
		start <= 1'b0;

		i = 0;
		while (pending_results.size() != 0 && i < STALL_LIMIT) begin
			@(posedge clk);
			i++;
		end
		repeat (20) @(posedge clk);
		$display("covered %0d words in, %0d results out, %0d dispatches", words_in, words_out,
			dispatch_seen);
		$display("bursts: idle-stack overflow, pending-queue overflow, pool refill");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d errors, %0d results missing", errors, pending_results.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
